@@ src/tkni_pkg.sv @@
// tkni_pkg: shared types and constants of the top-k nearest insertion list
// holds field widths, action and outcome codes, the token and emit structs
// no dependencies
package tkni_pkg;

  localparam int ID_W    = 20;
  localparam int DIST_W  = 32;
  localparam int RANK_W  = 3;
  localparam int ACT_W   = 2;
  localparam int OUTC_W  = 3;
  localparam int CNT_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // readout returns at most this many entries
  localparam int RES_LIMIT = 8;

  localparam logic [CNT_W-1:0] ACTIVE_COUNT_RST = 4'd8;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_ACTIVE_COUNT = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_OFFER = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [OUTC_W-1:0] {
    OUT_STORE  = 3'd0,
    OUT_INSERT = 3'd1,
    OUT_DUP    = 3'd2,
    OUT_REJECT = 3'd3,
    OUT_CLEAR  = 3'd4,
    OUT_READ   = 3'd5
  } outcome_e;

  // progress of an offer as it walks the chain
  typedef enum logic [1:0] {
    SC_SEARCH = 2'd0,
    SC_SHIFT  = 2'd1,
    SC_DONE   = 2'd2
  } scan_e;

  // token handed from cell to cell; id/distance carry the candidate while
  // searching and the displaced entry while shifting
  typedef struct packed {
    logic                valid;
    action_e             op;
    scan_e               scan;
    logic [ID_W-1:0]     id;
    logic [DIST_W-1:0]   distance;
    logic                carry_valid;
    outcome_e            outcome;
    logic [RANK_W-1:0]   rank;
  } token_t;

  // readout entry produced by one cell
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [RANK_W-1:0]   rank;
    logic                entry_valid;
    logic [ID_W-1:0]     id;
    logic [DIST_W-1:0]   distance;
  } emit_t;

endpackage

@@ src/tkni_cell.sv @@
// tkni_cell: one slot of the sorted neighbour chain
// holds one entry, processes the passing token and hands it to the next cell
// depends on tkni_pkg
module tkni_cell #(
  parameter int INDEX = 0,
  parameter int KW    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [KW-1:0]     k_eff_i,
  input  tkni_pkg::token_t  tok_i,
  input  logic              next_valid_i,
  output logic              valid_o,
  output tkni_pkg::token_t  tok_o,
  output tkni_pkg::emit_t   emit_o
);

  logic                          valid_q, valid_d;
  logic [tkni_pkg::ID_W-1:0]     id_q, id_d;
  logic [tkni_pkg::DIST_W-1:0]   dist_q, dist_d;
  logic                          tok_vld_q;
  tkni_pkg::token_t              tok_pay_q, tok_d;
  logic                          in_range;
  logic                          last_entry;

  assign in_range   = (KW'(INDEX) < k_eff_i);
  assign last_entry = (KW'(INDEX + 1) == k_eff_i) || (INDEX == tkni_pkg::RES_LIMIT - 1) ||
                      !next_valid_i;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    id_d    = id_q;
    dist_d  = dist_q;
    emit_o  = '0;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        tkni_pkg::ACT_CLEAR: begin
          valid_d = 1'b0;
        end
        tkni_pkg::ACT_OFFER: begin
          if (in_range) begin
            unique case (tok_i.scan)
              tkni_pkg::SC_SEARCH: begin
                if (!valid_q) begin
                  valid_d       = 1'b1;
                  id_d          = tok_i.id;
                  dist_d        = tok_i.distance;
                  tok_d.scan    = tkni_pkg::SC_DONE;
                  tok_d.outcome = tkni_pkg::OUT_STORE;
                  tok_d.rank    = tkni_pkg::RANK_W'(INDEX);
                end else if (id_q == tok_i.id) begin
                  tok_d.scan    = tkni_pkg::SC_DONE;
                  tok_d.outcome = tkni_pkg::OUT_DUP;
                  tok_d.rank    = tkni_pkg::RANK_W'(INDEX);
                end else if (dist_q > tok_i.distance) begin
                  valid_d           = 1'b1;
                  id_d              = tok_i.id;
                  dist_d            = tok_i.distance;
                  tok_d.scan        = tkni_pkg::SC_SHIFT;
                  tok_d.carry_valid = valid_q;
                  tok_d.id          = id_q;
                  tok_d.distance    = dist_q;
                  tok_d.outcome     = tkni_pkg::OUT_INSERT;
                  tok_d.rank        = tkni_pkg::RANK_W'(INDEX);
                end
              end
              tkni_pkg::SC_SHIFT: begin
                // swap the carried entry with this slot
                valid_d           = tok_i.carry_valid;
                id_d              = tok_i.id;
                dist_d            = tok_i.distance;
                tok_d.carry_valid = valid_q;
                tok_d.id          = id_q;
                tok_d.distance    = dist_q;
              end
              default: begin
              end
            endcase
          end
        end
        tkni_pkg::ACT_READ: begin
          if (in_range && valid_q) begin
            emit_o.valid       = 1'b1;
            emit_o.last        = last_entry;
            emit_o.rank        = tkni_pkg::RANK_W'(INDEX);
            emit_o.entry_valid = 1'b1;
            emit_o.id          = id_q;
            emit_o.distance    = dist_q;
            if (last_entry) begin
              tok_d.valid = 1'b0;
            end
          end else if (INDEX == 0) begin
            // nothing stored: a single empty entry
            emit_o.valid = 1'b1;
            emit_o.last  = 1'b1;
            tok_d.valid  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else if (advance_i) begin
      valid_q   <= valid_d;
      tok_vld_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      id_q      <= id_d;
      dist_q    <= dist_d;
      tok_pay_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_pay_q;
    tok_o.valid = tok_vld_q;
  end

  assign valid_o = valid_q;

endmodule

@@ src/top_k_nearest_insertion.sv @@
// top_k_nearest_insertion: k nearest candidates kept sorted in a chain of cells
// order: an offer or clear token passes through the register of every cell in turn, and
// its result is then taken into the output register; the readout entry of rank 0 is
// registered in the same cycle the readout is accepted, each further rank one cell later
// throughput: one transaction in flight; the token walks one cell per cycle while the
// output register is not stalled
// reset: all slots empty, active_count 8, no transaction in flight
// depends on tkni_pkg and tkni_cell
module top_k_nearest_insertion #(
  parameter int MAX_NEIGHBOURS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tkni_pkg::ACT_W-1:0]    action_i,
  input  logic [tkni_pkg::ID_W-1:0]     candidate_id_i,
  input  logic [tkni_pkg::DIST_W-1:0]   candidate_distance_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tkni_pkg::OUTC_W-1:0]   outcome_o,
  output logic [tkni_pkg::RANK_W-1:0]   rank_o,
  output logic                          entry_valid_o,
  output logic [tkni_pkg::ID_W-1:0]     entry_id_o,
  output logic [tkni_pkg::DIST_W-1:0]   entry_distance_o,
  output logic                          last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkni_pkg::ADDR_W-1:0]   paddr,
  input  logic [tkni_pkg::DATA_W-1:0]   pwdata,
  output logic [tkni_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // width that holds the effective count 0..MAX_NEIGHBOURS
  localparam int KW = $clog2(MAX_NEIGHBOURS + 1);

  // configuration register
  logic [tkni_pkg::CNT_W-1:0] active_count_q, active_count_d;
  logic                       cfg_write;
  logic [KW-1:0]              k_eff;

  // chain wiring: tok_chain[i] enters cell i, tok_chain[N] leaves the last cell
  tkni_pkg::token_t tok_chain [MAX_NEIGHBOURS+1];
  logic             slot_vld  [MAX_NEIGHBOURS+1];
  tkni_pkg::emit_t  emits     [MAX_NEIGHBOURS];
  tkni_pkg::emit_t  emit_any;

  // control
  logic advance;
  logic accept;
  logic launch;
  logic busy_q, busy_d;

  // result selection and output register
  logic                          res_valid;
  logic                          res_last;
  tkni_pkg::outcome_e            res_outcome;
  logic [tkni_pkg::RANK_W-1:0]   res_rank;
  logic                          res_entry_valid;
  logic [tkni_pkg::ID_W-1:0]     res_id;
  logic [tkni_pkg::DIST_W-1:0]   res_dist;
  logic                          out_valid_q, out_valid_d;
  logic [tkni_pkg::OUTC_W-1:0]   outcome_q;
  logic [tkni_pkg::RANK_W-1:0]   rank_q;
  logic                          entry_valid_q;
  logic [tkni_pkg::ID_W-1:0]     entry_id_q;
  logic [tkni_pkg::DIST_W-1:0]   entry_distance_q;
  logic                          last_q;

  // ---------------------------------------------------------------------------
  // configuration: one register, active_count, at byte address 0
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2:2] == tkni_pkg::REG_ACTIVE_COUNT);

  always_comb begin
    active_count_d = active_count_q;
    if (cfg_write) begin
      active_count_d = pwdata[tkni_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2:2] == tkni_pkg::REG_ACTIVE_COUNT) begin
      prdata = {(tkni_pkg::DATA_W - tkni_pkg::CNT_W)'(0), active_count_q};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= tkni_pkg::ACTIVE_COUNT_RST;
    end else begin
      active_count_q <= active_count_d;
    end
  end

  // effective k: active_count capped at the number of cells
  always_comb begin
    if (32'(active_count_q) > 32'(MAX_NEIGHBOURS)) begin
      k_eff = KW'(MAX_NEIGHBOURS);
    end else begin
      k_eff = KW'(active_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the whole chain moves only when the output register can take
  // a result, so a stalled readout freezes the token in place
  // ---------------------------------------------------------------------------
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && advance;
  assign accept     = in_valid_i && in_ready_o;
  // the unused action code is taken but starts no token
  assign launch     = accept && ((action_i == tkni_pkg::ACT_CLEAR) ||
                                 (action_i == tkni_pkg::ACT_OFFER) ||
                                 (action_i == tkni_pkg::ACT_READ));

  // new token enters cell 0 straight from the input ports
  always_comb begin
    tok_chain[0]             = '0;
    tok_chain[0].valid       = launch;
    tok_chain[0].op          = tkni_pkg::action_e'(action_i);
    tok_chain[0].scan        = tkni_pkg::SC_SEARCH;
    tok_chain[0].id          = candidate_id_i;
    tok_chain[0].distance    = candidate_distance_i;
    tok_chain[0].carry_valid = 1'b0;
    tok_chain[0].outcome     = tkni_pkg::OUT_REJECT;
    tok_chain[0].rank        = '0;
  end

  // ---------------------------------------------------------------------------
  // chain of slot cells
  // ---------------------------------------------------------------------------
  assign slot_vld[MAX_NEIGHBOURS] = 1'b0;

  for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
    tkni_cell #(
      .INDEX (g),
      .KW    (KW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .advance_i    (advance),
      .k_eff_i      (k_eff),
      .tok_i        (tok_chain[g]),
      .next_valid_i (slot_vld[g+1]),
      .valid_o      (slot_vld[g]),
      .tok_o        (tok_chain[g+1]),
      .emit_o       (emits[g])
    );
  end

  // only the cell holding the token emits, so an or over all cells selects it
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      emit_any = emit_any | emits[i];
    end
  end

  // ---------------------------------------------------------------------------
  // result: readout entries come from the cells, offer and clear results from
  // the token as it leaves the last cell
  // ---------------------------------------------------------------------------
  always_comb begin
    res_valid       = 1'b0;
    res_last        = 1'b0;
    res_outcome     = tkni_pkg::OUT_READ;
    res_rank        = '0;
    res_entry_valid = 1'b0;
    res_id          = '0;
    res_dist        = '0;
    if (emit_any.valid) begin
      res_valid       = 1'b1;
      res_last        = emit_any.last;
      res_rank        = emit_any.rank;
      res_entry_valid = emit_any.entry_valid;
      res_id          = emit_any.id;
      res_dist        = emit_any.distance;
    end else if (tok_chain[MAX_NEIGHBOURS].valid &&
                 (tok_chain[MAX_NEIGHBOURS].op != tkni_pkg::ACT_READ)) begin
      res_valid = 1'b1;
      res_last  = 1'b1;
      if (tok_chain[MAX_NEIGHBOURS].op == tkni_pkg::ACT_CLEAR) begin
        res_outcome = tkni_pkg::OUT_CLEAR;
      end else begin
        res_outcome = tok_chain[MAX_NEIGHBOURS].outcome;
        res_rank    = tok_chain[MAX_NEIGHBOURS].rank;
      end
    end
  end

  // busy from launch until the last result of the transaction is registered
  always_comb begin
    busy_d = busy_q;
    if (launch) begin
      busy_d = 1'b1;
    end
    if (advance && res_valid && res_last) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      outcome_q        <= res_outcome;
      rank_q           <= res_rank;
      entry_valid_q    <= res_entry_valid;
      entry_id_q       <= res_id;
      entry_distance_q <= res_dist;
      last_q           <= res_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign rank_o           = rank_q;
  assign entry_valid_o    = entry_valid_q;
  assign entry_id_o       = entry_id_q;
  assign entry_distance_o = entry_distance_q;
  assign last_o           = last_q;

endmodule

@@ src/tkni_checker.sv @@
// tkni_checker: port-level checks of the top-k nearest insertion list
// bound to top_k_nearest_insertion; depends on tkni_pkg
module tkni_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [tkni_pkg::ACT_W-1:0]    action_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [tkni_pkg::OUTC_W-1:0]   outcome_o,
  input  logic [tkni_pkg::RANK_W-1:0]   rank_o,
  input  logic                          entry_valid_o,
  input  logic [tkni_pkg::ID_W-1:0]     entry_id_o,
  input  logic [tkni_pkg::DIST_W-1:0]   entry_distance_o,
  input  logic                          last_o
);

  // a stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(outcome_o) &&
      $stable(rank_o) && $stable(entry_id_o) && $stable(entry_distance_o) &&
      $stable(last_o))
    else $error("result changed while stalled");

  // offer and clear results carry no entry and end the transaction; the unused code gives no result
  a_non_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != tkni_pkg::OUT_READ) |->
      !entry_valid_o && (entry_id_o == '0) && (entry_distance_o == '0) && last_o)
    else $error("non-readout result carries entry data");

  // an empty readout entry is the single result at rank zero
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == tkni_pkg::OUT_READ) && !entry_valid_o |->
      (rank_o == '0) && last_o && (entry_id_o == '0) && (entry_distance_o == '0))
    else $error("malformed empty readout");

  // an offer walks the whole chain, so no new transaction right after one
  a_offer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == tkni_pkg::ACT_OFFER) |=> !in_ready_o)
    else $error("input ready while an offer is in flight");

endmodule

bind top_k_nearest_insertion tkni_checker u_tkni_checker (.*);
